### rtl/mrpt_pkg.sv
`timescale 1ns / 1ps
package mrpt_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_BASE,
    ST_POW,
    ST_SQR,
    ST_MUL,
    ST_DONE
  } eng_state_t;

  typedef enum logic [1:0] {
    MUL_POW_ACC,
    MUL_POW_BASE,
    MUL_SQR
  } mul_op_t;

  // Bit k is set when k is prime, for k below 64.
  localparam logic [63:0] PRIME_MASK = 64'h2820_8a20_a08a_28ac;

  function automatic logic small_prime(input logic [6:0] v);
    return !v[6] && PRIME_MASK[v[5:0]];
  endfunction

endpackage

### rtl/mrpt_if.sv
`timescale 1ns / 1ps
interface mrpt_if #(
  parameter int W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/mrpt_front.sv
`timescale 1ns / 1ps
// Accepts candidates, settles the trivial ones and queues them as flagged answers beside the odd ones.
module mrpt_front #(
  parameter int NUM_WIDTH = 63
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [NUM_WIDTH-1:0] in_candidate,
  output logic                 q_valid,
  input  logic                 q_ready,
  output logic [NUM_WIDTH:0]   q_data
);
  // Queue entry: {trivial flag or candidate}. Top bit set means trivial,
  // bit 0 then holds the answer.
  localparam int DEPTH = 2;
  logic [NUM_WIDTH:0] mem_r [DEPTH];
  logic               wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               trivial, push, pop;
  logic [NUM_WIDTH:0] entry;

  assign trivial  = (in_candidate <= NUM_WIDTH'(2)) || !in_candidate[0];
  assign entry    = trivial ? {1'b1, NUM_WIDTH'(in_candidate == NUM_WIDTH'(2))}
                            : {1'b0, in_candidate};
  assign in_ready = (cnt_r != 2'(DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = mem_r[rp_r];
  assign wp_nxt   = push ? ~wp_r : wp_r;
  assign rp_nxt   = pop ? ~rp_r : rp_r;
  assign cnt_nxt  = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= entry;
  end
endmodule

### rtl/mrpt_mulmod.sv
`timescale 1ns / 1ps
// Shift-and-add modular multiply, one bit of b per cycle, MSB first.
module mrpt_mulmod #(
  parameter int NUM_WIDTH = 63
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_WIDTH-1:0] a,
  input  logic [NUM_WIDTH-1:0] b,
  input  logic [NUM_WIDTH-1:0] m,
  output logic                 done,
  output logic [NUM_WIDTH-1:0] p
);
  localparam int CW = $clog2(NUM_WIDTH + 1);
  logic [NUM_WIDTH-1:0] acc_r, acc_nxt, a_r, b_r, m_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r, done_r;
  logic [NUM_WIDTH:0]   dbl, sum;
  logic [NUM_WIDTH-1:0] dbl_m;

  always_comb begin
    dbl   = {acc_r, 1'b0};
    dbl_m = (dbl >= {1'b0, m_r}) ? NUM_WIDTH'(dbl - {1'b0, m_r}) : NUM_WIDTH'(dbl);
    sum   = {1'b0, dbl_m} + {1'b0, a_r};
    if (b_r[NUM_WIDTH-1])
      acc_nxt = (sum >= {1'b0, m_r}) ? NUM_WIDTH'(sum - {1'b0, m_r}) : NUM_WIDTH'(sum);
    else
      acc_nxt = dbl_m;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(NUM_WIDTH - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= b;
      m_r   <= m;
      cnt_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[NUM_WIDTH-2:0], 1'b0};
      cnt_r <= cnt_r + CW'(1);
    end
  end
  assign done = done_r;
  assign p    = acc_r;
endmodule

### rtl/mrpt_engine.sv
`timescale 1ns / 1ps
// Runs the Miller-Rabin rounds for one queued word on a shared mulmod.
module mrpt_engine #(
  parameter int NUM_WIDTH  = 63,
  parameter int BASE_LIMIT = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  logic [NUM_WIDTH:0]   q_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_is_prime
);
  localparam int BW = $clog2(BASE_LIMIT + 1);
  localparam int SW = $clog2(NUM_WIDTH + 1);

  mrpt_pkg::eng_state_t st_r, st_nxt;
  mrpt_pkg::mul_op_t    op_r;
  logic [NUM_WIDTH-1:0] n_r, r_r, e_r, base_r, acc_r, c_r;
  logic [SW-1:0]        s_r, j_r;
  logic [BW-1:0]        b_r;
  logic                 res_r, ovalid_r;
  logic                 mstart, mdone;
  logic [NUM_WIDTH-1:0] ma, mb, mp;
  logic                 bprime, bok, b_in, sq_fail;
  logic [NUM_WIDTH-1:0] nm1;

  assign nm1     = n_r - NUM_WIDTH'(1);
  assign bprime  = mrpt_pkg::small_prime(7'(b_r));
  assign bok     = (NUM_WIDTH'(b_r) < n_r);
  assign b_in    = (32'(b_r) < BASE_LIMIT);
  assign sq_fail = (mp == NUM_WIDTH'(1)) && (c_r != NUM_WIDTH'(1)) && (c_r != nm1);

  mrpt_mulmod #(.NUM_WIDTH(NUM_WIDTH)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb), .m(n_r),
    .done(mdone), .p(mp)
  );

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      mrpt_pkg::ST_IDLE: begin
        if (q_valid && !ovalid_r)
          st_nxt = q_data[NUM_WIDTH] ? mrpt_pkg::ST_DONE : mrpt_pkg::ST_SPLIT;
      end
      mrpt_pkg::ST_SPLIT: if (r_r[0]) st_nxt = mrpt_pkg::ST_BASE;
      mrpt_pkg::ST_BASE: begin
        if (!b_in || !bok) st_nxt = mrpt_pkg::ST_DONE;
        else if (bprime)   st_nxt = mrpt_pkg::ST_POW;
      end
      mrpt_pkg::ST_POW: st_nxt = (e_r == '0) ? mrpt_pkg::ST_SQR : mrpt_pkg::ST_MUL;
      mrpt_pkg::ST_SQR: begin
        if (j_r == s_r)
          st_nxt = (c_r != NUM_WIDTH'(1)) ? mrpt_pkg::ST_DONE : mrpt_pkg::ST_BASE;
        else
          st_nxt = mrpt_pkg::ST_MUL;
      end
      mrpt_pkg::ST_MUL: begin
        if (mdone) begin
          unique case (op_r)
            mrpt_pkg::MUL_POW_ACC:  st_nxt = mrpt_pkg::ST_MUL;
            mrpt_pkg::MUL_POW_BASE: st_nxt = mrpt_pkg::ST_POW;
            mrpt_pkg::MUL_SQR:      st_nxt = sq_fail ? mrpt_pkg::ST_DONE : mrpt_pkg::ST_SQR;
            default:                st_nxt = mrpt_pkg::ST_IDLE;
          endcase
        end
      end
      mrpt_pkg::ST_DONE: st_nxt = mrpt_pkg::ST_IDLE;
      default:           st_nxt = mrpt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (st_r == mrpt_pkg::ST_IDLE) && !ovalid_r;
    mstart  = 1'b0;
    ma      = c_r;
    mb      = c_r;
    unique case (st_r)
      mrpt_pkg::ST_POW: begin
        if (e_r != '0) begin
          mstart = 1'b1;
          ma     = e_r[0] ? acc_r : base_r;
          mb     = base_r;
        end
      end
      mrpt_pkg::ST_SQR: mstart = (j_r != s_r);
      mrpt_pkg::ST_MUL: begin
        // square the base right after the accumulator update
        if (mdone && op_r == mrpt_pkg::MUL_POW_ACC) begin
          mstart = 1'b1;
          ma     = base_r;
          mb     = base_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid    = ovalid_r;
  assign out_is_prime = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= mrpt_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == mrpt_pkg::ST_DONE) ovalid_r <= 1'b1;
      else if (ovalid_r && out_ready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      mrpt_pkg::ST_IDLE: begin
        if (q_valid && !ovalid_r) begin
          res_r <= q_data[0];
          n_r   <= q_data[NUM_WIDTH-1:0];
          r_r   <= q_data[NUM_WIDTH-1:0] - NUM_WIDTH'(1);
          s_r   <= '0;
          b_r   <= BW'(2);
        end
      end
      mrpt_pkg::ST_SPLIT: begin
        if (!r_r[0]) begin
          r_r <= r_r >> 1;
          s_r <= s_r + SW'(1);
        end
        res_r <= 1'b1;
      end
      mrpt_pkg::ST_BASE: begin
        if (b_in && bok) begin
          if (!bprime) begin
            b_r <= b_r + BW'(1);
          end else begin
            base_r <= NUM_WIDTH'(b_r);
            acc_r  <= NUM_WIDTH'(1);
            e_r    <= r_r;
          end
        end
      end
      mrpt_pkg::ST_POW: begin
        if (e_r == '0) begin
          c_r <= acc_r;
          j_r <= '0;
        end else begin
          op_r <= e_r[0] ? mrpt_pkg::MUL_POW_ACC : mrpt_pkg::MUL_POW_BASE;
        end
      end
      mrpt_pkg::ST_SQR: begin
        if (j_r == s_r) begin
          if (c_r != NUM_WIDTH'(1)) res_r <= 1'b0;
          else b_r <= b_r + BW'(1);
        end else begin
          op_r <= mrpt_pkg::MUL_SQR;
        end
      end
      mrpt_pkg::ST_MUL: begin
        if (mdone) begin
          unique case (op_r)
            mrpt_pkg::MUL_POW_ACC: begin
              acc_r <= mp;
              op_r  <= mrpt_pkg::MUL_POW_BASE;
            end
            mrpt_pkg::MUL_POW_BASE: begin
              base_r <= mp;
              e_r    <= e_r >> 1;
            end
            mrpt_pkg::MUL_SQR: begin
              if (sq_fail) begin
                res_r <= 1'b0;
              end else begin
                c_r <= mp;
                j_r <= j_r + SW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end
endmodule

### rtl/miller_rabin_prime_test_unit.sv
`timescale 1ns / 1ps
// Work: each modular multiply runs on one shared bit-serial mulmod;
// an odd 63-bit candidate takes up to roughly 11 bases times 125 multiplies.
// Trivial candidates skip the Miller-Rabin rounds.
// Throughput: one candidate at a time in the engine; a two-word queue decouples input.
// Reset: synchronous active-low rst_n clears queue and engine control.
module miller_rabin_prime_test_unit #(
  parameter int BASE_LIMIT = 32,
  parameter int NUM_WIDTH  = 63
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [NUM_WIDTH-1:0] in_candidate,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_is_prime
);
  mrpt_if #(.W(NUM_WIDTH + 1)) q_ch ();

  mrpt_front #(.NUM_WIDTH(NUM_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_candidate(in_candidate), .q_valid(q_ch.valid), .q_ready(q_ch.ready),
    .q_data(q_ch.data)
  );

  mrpt_engine #(.NUM_WIDTH(NUM_WIDTH), .BASE_LIMIT(BASE_LIMIT)) u_engine (
    .clk(clk), .rst_n(rst_n), .q_valid(q_ch.valid), .q_ready(q_ch.ready),
    .q_data(q_ch.data), .out_valid(out_valid), .out_ready(out_ready),
    .out_is_prime(out_is_prime)
  );
endmodule
